// File: design/lcs_pkg.sv
// Shared types and constants for the launch control sequencer.
package lcs_pkg;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic [2:0] {
      REG_READY_ACCEL_LIMIT = 3'd0,
      REG_READY_BRAKE_LIMIT = 3'd1,
      REG_READY_SPEED_LIMIT = 3'd2,
      REG_GO_ACCEL_LEVEL    = 3'd3,
      REG_STOP_ACCEL_LEVEL  = 3'd4,
      REG_RAMP_SLOPE        = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [11:0] ready_accel_limit;
      logic [10:0] ready_brake_limit;
      logic [15:0] ready_speed_limit;
      logic [11:0] go_accel_level;
      logic [11:0] stop_accel_level;
      logic [23:0] ramp_slope;
   } lcs_cfg_type;

   localparam logic [11:0] RST_READY_ACCEL_LIMIT = 12'd100;
   localparam logic [10:0] RST_READY_BRAKE_LIMIT = 11'd100;
   localparam logic [15:0] RST_READY_SPEED_LIMIT = 16'd100;
   localparam logic [11:0] RST_GO_ACCEL_LEVEL    = 12'd1500;
   localparam logic [11:0] RST_STOP_ACCEL_LEVEL  = 12'd500;
   localparam logic [23:0] RST_RAMP_SLOPE        = 24'd429556;

   localparam logic signed [12:0] LAUNCH_TORQUE = 13'sd2142;
   localparam logic [10:0]        RAMP_OFFSET   = 11'd1500;
   localparam logic [14:0]        SPEED_CAP     = 15'd20000;
   localparam logic [10:0]        REGEN_FLOOR   = 11'd1500;
   localparam logic [15:0]        TIMER_MAX     = 16'hFFFF;

endpackage

// File: design/lcs_csr.sv
// Configuration register file with its APB-style access port.
module lcs_csr
   import lcs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output lcs_cfg_type               cfg
);

   lcs_cfg_type   cfg_ff;
   reg_index_type reg_index;
   logic          write_en;

   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[CSR_ADDR_WIDTH-1:2]);
   assign write_en  = psel && penable && pwrite && pready;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ready_accel_limit <= RST_READY_ACCEL_LIMIT;
         cfg_ff.ready_brake_limit <= RST_READY_BRAKE_LIMIT;
         cfg_ff.ready_speed_limit <= RST_READY_SPEED_LIMIT;
         cfg_ff.go_accel_level    <= RST_GO_ACCEL_LEVEL;
         cfg_ff.stop_accel_level  <= RST_STOP_ACCEL_LEVEL;
         cfg_ff.ramp_slope        <= RST_RAMP_SLOPE;
      end else if (write_en) begin
         case (reg_index)
            REG_READY_ACCEL_LIMIT: cfg_ff.ready_accel_limit <= pwdata[11:0];
            REG_READY_BRAKE_LIMIT: cfg_ff.ready_brake_limit <= pwdata[10:0];
            REG_READY_SPEED_LIMIT: cfg_ff.ready_speed_limit <= pwdata[15:0];
            REG_GO_ACCEL_LEVEL:    cfg_ff.go_accel_level    <= pwdata[11:0];
            REG_STOP_ACCEL_LEVEL:  cfg_ff.stop_accel_level  <= pwdata[11:0];
            REG_RAMP_SLOPE:        cfg_ff.ramp_slope        <= pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_READY_ACCEL_LIMIT: prdata = 32'(cfg_ff.ready_accel_limit);
         REG_READY_BRAKE_LIMIT: prdata = 32'(cfg_ff.ready_brake_limit);
         REG_READY_SPEED_LIMIT: prdata = 32'(cfg_ff.ready_speed_limit);
         REG_GO_ACCEL_LEVEL:    prdata = 32'(cfg_ff.go_accel_level);
         REG_STOP_ACCEL_LEVEL:  prdata = 32'(cfg_ff.stop_accel_level);
         REG_RAMP_SLOPE:        prdata = 32'(cfg_ff.ramp_slope);
         default:               prdata = '0;
      endcase
   end

endmodule

// File: design/launch_control_sequencer.sv
// Launch control sequencer top level: input register, phase machine, result register.
//
// Usage:
//   One transaction on the req_ channel carries one control tick (pedals, top
//   motor speed, elapsed milliseconds, launch enable). Each tick yields exactly
//   one transaction on the rsp_ channel with the torque and speed setpoints and
//   the phase after the tick.
//   Path: a tick accepted into the input register shows its result as rsp_valid
//   once it moves into the result register. Throughput: one tick per cycle
//   while rsp_stall is low, set by the single pass of compare, timer add and
//   one 24x16 multiply between the input register and the result register.
//   Stall: while rsp_stall holds a waiting result, one more tick is taken
//   into the input register; req_stall then rises until the result drains.
//   Reset (synchronous, active high): phase disarmed, launch timer and held
//   setpoints zero, both stages empty, configuration back to defaults.
//   Configuration: csr_ APB-style port, register i at byte address 4*i; write
//   only while no tick is in flight.
module launch_control_sequencer
   import lcs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // tick input
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [11:0]               req_accel_level,
   input  logic [10:0]               req_brake_level,
   input  logic [15:0]               req_top_motor_speed,
   input  logic [7:0]                req_elapsed_ms,
   input  logic                      req_launch_enabled,
   // setpoint output
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [12:0]        rsp_torque_command,
   output logic [14:0]               rsp_speed_command,
   output logic [1:0]                rsp_launch_phase,
   // configuration
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   typedef enum logic [1:0] {
      PH_DISARMED = 2'd0,
      PH_READY    = 2'd1,
      PH_LAUNCH   = 2'd2
   } phase_type;

   lcs_cfg_type cfg;

   lcs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Input register stage.
   logic        s1_valid_ff;
   logic [11:0] s1_accel_ff;
   logic [10:0] s1_brake_ff;
   logic [15:0] s1_speed_ff;
   logic [7:0]  s1_elapsed_ff;
   logic        s1_enabled_ff;

   // Sequencer state. The result registers double as the held setpoints,
   // since they change only when a tick is processed.
   phase_type          phase_ff, phase_in;
   logic [15:0]        timer_ff, timer_in;
   logic               rsp_valid_ff;
   logic signed [12:0] torque_ff, torque_in;
   logic [14:0]        speed_ff, speed_in;

   logic        advance;
   logic [16:0] timer_sum;
   logic [15:0] timer_adv;
   logic [39:0] ramp_prod;
   logic [24:0] ramp_sum;
   logic [14:0] ramp_speed;
   logic [10:0] brake_cap;
   logic signed [12:0] regen_torque;

   // Move a tick into the result register when the result slot is free or draining.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && rsp_valid_ff && rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_torque_command = torque_ff;
   assign rsp_speed_command  = speed_ff;
   assign rsp_launch_phase   = phase_ff;

   // Advance the launch timer, saturating at its top value.
   assign timer_sum = {1'b0, timer_ff} + 17'(s1_elapsed_ff);
   assign timer_adv = timer_sum[16] ? TIMER_MAX : timer_sum[15:0];

   // Speed ramp: Q8.16 slope times ms, drop the fraction, add offset, cap.
   assign ramp_prod  = 40'(cfg.ramp_slope) * 40'(timer_adv);
   assign ramp_sum   = {1'b0, ramp_prod[39:16]} + 25'(RAMP_OFFSET);
   assign ramp_speed = (ramp_sum > 25'(SPEED_CAP)) ? SPEED_CAP : ramp_sum[14:0];

   // Regen torque is minus the brake, floored at the regen limit.
   assign brake_cap    = (s1_brake_ff > REGEN_FLOOR) ? REGEN_FLOOR : s1_brake_ff;
   assign regen_torque = -$signed({2'b00, brake_cap});

   always_comb begin
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      torque_in = torque_ff;
      speed_in  = speed_ff;
      if (!s1_enabled_ff) begin
         // Drop to disarmed with zero setpoints.
         phase_in  = PH_DISARMED;
         timer_in  = '0;
         torque_in = '0;
         speed_in  = '0;
      end else begin
         case (phase_ff)
            PH_READY: begin
               torque_in = '0;
               speed_in  = '0;
               timer_in  = '0;
               if (s1_brake_ff >= cfg.ready_brake_limit ||
                   s1_speed_ff >= cfg.ready_speed_limit) begin
                  phase_in = PH_DISARMED;
               end else if (s1_accel_ff >= cfg.go_accel_level) begin
                  phase_in = PH_LAUNCH;
               end
            end
            PH_LAUNCH: begin
               if (s1_accel_ff <= cfg.stop_accel_level ||
                   s1_brake_ff >= cfg.ready_brake_limit) begin
                  // Abort: repeat the previous setpoints, keep the timer.
                  phase_in = PH_DISARMED;
               end else begin
                  timer_in  = timer_adv;
                  torque_in = LAUNCH_TORQUE;
                  speed_in  = ramp_speed;
               end
            end
            default: begin
               torque_in = regen_torque;
               speed_in  = '0;
               timer_in  = '0;
               phase_in  = PH_DISARMED;
               if (s1_accel_ff < cfg.ready_accel_limit &&
                   s1_brake_ff < cfg.ready_brake_limit &&
                   s1_speed_ff < cfg.ready_speed_limit) begin
                  phase_in = PH_READY;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_DISARMED;
         timer_ff     <= '0;
         torque_ff    <= '0;
         speed_ff     <= '0;
      end else begin
         // Capture a new tick whenever the input register is not held.
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            timer_ff     <= timer_in;
            torque_ff    <= torque_in;
            speed_ff     <= speed_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Tick payload needs no reset; it is qualified by s1_valid_ff.
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_accel_ff   <= req_accel_level;
         s1_brake_ff   <= req_brake_level;
         s1_speed_ff   <= req_top_motor_speed;
         s1_elapsed_ff <= req_elapsed_ms;
         s1_enabled_ff <= req_launch_enabled;
      end
   end

endmodule
